[rtl/core/mtrb_pkg.sv]
// ----------------------------------------------------------------------------
// mtrb_pkg
// Types and codes shared by the multi-terminal ring buffer unit.
// ----------------------------------------------------------------------------
package mtrb_pkg;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_KEY    = 2'd2;
    localparam logic [1:0] OP_SWITCH = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_INDEX = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_EMPTY     = 3'd3;
    localparam logic [2:0] STS_NO_CHANGE = 3'd4;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] terminal_index;
        logic [7:0] data_byte;
        logic       burst_last;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_byte;
        logic       echo_valid;
        logic [8:0] input_fill;
        logic [8:0] output_fill;
        logic [3:0] current_terminal;
        logic       last_of_burst;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0] opcode;
        logic       bad_index;
        logic [3:0] terminal;
        logic [7:0] data_byte;
        logic       burst_last;
    } cmd_t;

    typedef enum logic {
        BK_EXEC,
        BK_READ
    } back_state_t;

endpackage

[rtl/core/mtrb_front.sv]
// ----------------------------------------------------------------------------
// mtrb_front
// Accepts input words, checks the terminal index and queues commands.
// ----------------------------------------------------------------------------
module mtrb_front #(
    parameter int NUM_TERMINALS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mtrb_pkg::in_word_t s_word,
    output logic              cmd_valid,
    output mtrb_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    localparam int QP_W  = (mtrb_pkg::CMDQ_DEPTH > 1) ? $clog2(mtrb_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(mtrb_pkg::CMDQ_DEPTH + 1);

    mtrb_pkg::cmd_t   q_reg [mtrb_pkg::CMDQ_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mtrb_pkg::cmd_t   dec_cmd;
    logic             push;

    // key input ignores the index, everything else must name a real terminal
    always_comb begin
        dec_cmd.opcode     = s_word.opcode;
        dec_cmd.terminal   = s_word.terminal_index;
        dec_cmd.data_byte  = s_word.data_byte;
        dec_cmd.burst_last = s_word.burst_last;
        dec_cmd.bad_index  = (s_word.opcode != mtrb_pkg::OP_KEY) &&
                             ({1'b0, s_word.terminal_index} >= 5'(NUM_TERMINALS));
    end

    assign s_ready   = (cnt_reg != CNT_W'(mtrb_pkg::CMDQ_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(mtrb_pkg::CMDQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(mtrb_pkg::CMDQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && cmd_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

[rtl/core/mtrb_back.sv]
// ----------------------------------------------------------------------------
// mtrb_back
// Executes queued commands on the ring state and holds the result word.
// ----------------------------------------------------------------------------
module mtrb_back #(
    parameter int NUM_TERMINALS = 4,
    parameter int RING_DEPTH    = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  mtrb_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output mtrb_pkg::out_word_t m_word
);

    localparam int TERM_W = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEM_D  = NUM_TERMINALS * RING_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    mtrb_pkg::back_state_t state_reg, state_next;

    logic [PTR_W-1:0]  in_wp_reg   [NUM_TERMINALS];
    logic [PTR_W-1:0]  in_rp_reg   [NUM_TERMINALS];
    logic [FILL_W-1:0] in_fill_reg [NUM_TERMINALS];
    logic [PTR_W-1:0]  out_wp_reg  [NUM_TERMINALS];
    logic [FILL_W-1:0] out_fill_reg[NUM_TERMINALS];
    logic [PTR_W-1:0]  in_wp_next  [NUM_TERMINALS];
    logic [PTR_W-1:0]  in_rp_next  [NUM_TERMINALS];
    logic [FILL_W-1:0] in_fill_next[NUM_TERMINALS];
    logic [PTR_W-1:0]  out_wp_next [NUM_TERMINALS];
    logic [FILL_W-1:0] out_fill_next[NUM_TERMINALS];
    logic [TERM_W-1:0] cur_reg, cur_next;

    logic [7:0] in_ring_mem  [MEM_D];
    logic [7:0] out_ring_mem [MEM_D];
    logic [7:0] in_rdata_reg;

    mtrb_pkg::out_word_t pend_reg, pend_next;
    logic                pend_rd_reg, pend_rd_next;
    logic                m_valid_reg, m_valid_next;
    mtrb_pkg::out_word_t m_word_reg, m_word_next;

    logic [TERM_W-1:0] tgt;
    logic              have_tgt;
    logic              in_we, out_we, in_re;
    logic [ADDR_W-1:0] in_waddr, in_raddr, out_waddr;

    function automatic logic [ADDR_W-1:0] ring_addr(input logic [TERM_W-1:0] t,
                                                     input logic [PTR_W-1:0] p);
        ring_addr = ADDR_W'(t) * ADDR_W'(RING_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd_pop = (state_reg == mtrb_pkg::BK_EXEC) && cmd_valid &&
                     (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mtrb_pkg::BK_EXEC: begin
                if (cmd_pop) begin
                    state_next = mtrb_pkg::BK_READ;
                end
            end
            mtrb_pkg::BK_READ: begin
                state_next = mtrb_pkg::BK_EXEC;
            end
            default: begin
                state_next = mtrb_pkg::BK_EXEC;
            end
        endcase
    end

    // command execution and result word
    always_comb begin
        in_wp_next    = in_wp_reg;
        in_rp_next    = in_rp_reg;
        in_fill_next  = in_fill_reg;
        out_wp_next   = out_wp_reg;
        out_fill_next = out_fill_reg;
        cur_next      = cur_reg;
        pend_next     = pend_reg;
        pend_rd_next  = pend_rd_reg;
        in_we         = 1'b0;
        out_we        = 1'b0;
        in_re         = 1'b0;
        tgt           = (cmd.opcode == mtrb_pkg::OP_KEY) ? cur_reg
                      : cmd.terminal[TERM_W-1:0];
        have_tgt      = !cmd.bad_index;
        in_waddr      = ring_addr(tgt, in_wp_reg[tgt]);
        in_raddr      = ring_addr(tgt, in_rp_reg[tgt]);
        out_waddr     = ring_addr(tgt, out_wp_reg[tgt]);
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;

        if (cmd_pop) begin
            pend_next.status     = mtrb_pkg::STS_OK;
            pend_next.read_byte  = '0;
            pend_next.echo_valid = 1'b0;
            pend_rd_next         = 1'b0;
            if (cmd.bad_index) begin
                pend_next.status = mtrb_pkg::STS_BAD_INDEX;
            end else begin
                case (cmd.opcode)
                    mtrb_pkg::OP_KEY: begin
                        if (in_fill_reg[tgt] == FILL_W'(RING_DEPTH)) begin
                            pend_next.status = mtrb_pkg::STS_FULL;
                        end else begin
                            in_we             = 1'b1;
                            in_wp_next[tgt]   = ptr_inc(in_wp_reg[tgt]);
                            in_fill_next[tgt] = in_fill_reg[tgt] + 1'b1;
                        end
                    end
                    mtrb_pkg::OP_WRITE: begin
                        if (out_fill_reg[tgt] == FILL_W'(RING_DEPTH)) begin
                            pend_next.status = mtrb_pkg::STS_FULL;
                        end else begin
                            out_we               = 1'b1;
                            out_wp_next[tgt]     = ptr_inc(out_wp_reg[tgt]);
                            out_fill_next[tgt]   = out_fill_reg[tgt] + 1'b1;
                            pend_next.echo_valid = (tgt == cur_reg);
                        end
                    end
                    mtrb_pkg::OP_READ: begin
                        if (in_fill_reg[tgt] == '0) begin
                            pend_next.status = mtrb_pkg::STS_EMPTY;
                        end else begin
                            in_re             = 1'b1;
                            pend_rd_next      = 1'b1;
                            in_rp_next[tgt]   = ptr_inc(in_rp_reg[tgt]);
                            in_fill_next[tgt] = in_fill_reg[tgt] - 1'b1;
                        end
                    end
                    mtrb_pkg::OP_SWITCH: begin
                        if (tgt == cur_reg) begin
                            pend_next.status = mtrb_pkg::STS_NO_CHANGE;
                        end else begin
                            cur_next = tgt;
                        end
                    end
                    default: begin
                        pend_next.status = mtrb_pkg::STS_OK;
                    end
                endcase
            end
            pend_next.input_fill       = have_tgt ? 9'(in_fill_next[tgt]) : '0;
            pend_next.output_fill      = have_tgt ? 9'(out_fill_next[tgt]) : '0;
            pend_next.current_terminal = 4'(cur_next);
            pend_next.last_of_burst    = cmd.burst_last;
        end

        // ring read data is registered and used in the cycle after the command
        if (state_reg == mtrb_pkg::BK_READ) begin
            m_valid_next          = 1'b1;
            m_word_next           = pend_reg;
            m_word_next.read_byte = pend_rd_reg ? in_rdata_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mtrb_pkg::BK_EXEC;
            in_wp_reg    <= '{default: '0};
            in_rp_reg    <= '{default: '0};
            in_fill_reg  <= '{default: '0};
            out_wp_reg   <= '{default: '0};
            out_fill_reg <= '{default: '0};
            cur_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_wp_reg    <= in_wp_next;
            in_rp_reg    <= in_rp_next;
            in_fill_reg  <= in_fill_next;
            out_wp_reg   <= out_wp_next;
            out_fill_reg <= out_fill_next;
            cur_reg      <= cur_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        pend_rd_reg <= pend_rd_next;
        m_word_reg  <= m_word_next;
    end

    // ring stores
    always_ff @(posedge aclk) begin
        if (in_we) begin
            in_ring_mem[in_waddr] <= cmd.data_byte;
        end
        if (in_re) begin
            in_rdata_reg <= in_ring_mem[in_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_we) begin
            out_ring_mem[out_waddr] <= cmd.data_byte;
        end
    end

endmodule

[rtl/core/multi_terminal_ring_buffers_unit.sv]
// ----------------------------------------------------------------------------
// multi_terminal_ring_buffers_unit
// Per-terminal input and output byte rings with a current-terminal selector.
// ----------------------------------------------------------------------------
// Path: input accept into the command queue, then execute with ring read,
//   then the result register.
// Flow: a new command executes only after the registered ring memory read of
//   the last; a full result register stalls execute, then the queue and input.
// Reset: synchronous, active low; clears pointers, fill counts, the current
//   terminal and the queues. Ring memories are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module multi_terminal_ring_buffers_unit #(
    parameter int NUM_TERMINALS = 4,   // 1..16
    parameter int RING_DEPTH    = 256  // 2..511 bytes per ring
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  mtrb_pkg::in_word_t s_word,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output mtrb_pkg::out_word_t m_word
);

    // Front: decode and index check, two-entry command queue.
    // Back: one command at a time against the pointer/fill flops and rings,
    // then the result register that the m_ side drains.
    logic           cmd_valid;
    logic           cmd_pop;
    mtrb_pkg::cmd_t cmd;

    mtrb_front #(
        .NUM_TERMINALS (NUM_TERMINALS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mtrb_back #(
        .NUM_TERMINALS (NUM_TERMINALS),
        .RING_DEPTH    (RING_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

[rtl/core/mtrb_checker.sv]
// ----------------------------------------------------------------------------
// mtrb_checker
// Port-level checks on the ring buffer unit, bound to the top level.
// ----------------------------------------------------------------------------
module mtrb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input mtrb_pkg::out_word_t m_word
);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.status <= mtrb_pkg::STS_NO_CHANGE)
        else $error("status code out of range");

    a_bad_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == mtrb_pkg::STS_BAD_INDEX |->
            m_word.input_fill == '0 && m_word.output_fill == '0 &&
            m_word.read_byte == '0 && !m_word.echo_valid)
        else $error("bad index result carries data");

    a_echo_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.echo_valid |->
            m_word.status == mtrb_pkg::STS_OK && m_word.read_byte == '0 &&
            m_word.output_fill != '0)
        else $error("echo on a failed or non-write result");

endmodule

bind multi_terminal_ring_buffers_unit mtrb_checker u_mtrb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

[tb/sv/tb_multi_terminal_ring_buffers_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_terminal_ring_buffers_unit
// Self-checking bench for the multi-terminal ring buffer unit. A scoreboard
// tracks every terminal's rings and the current terminal, predicts one result
// word per accepted input word, and checks results in order. Stimulus is a
// short directed pass, then random runs of keys, reads, writes and switches
// (some long enough to fill and drain whole rings), plus noise words.
// ----------------------------------------------------------------------------
module tb_multi_terminal_ring_buffers_unit;

    localparam int NT           = 4;      // terminals in the unit under test
    localparam int DEPTH        = 256;    // bytes per ring
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int TARGET_ITEMS = 1350;   // random words, roughly
    localparam int CYCLE_LIMIT  = 400000; // far beyond the slowest legal run
    localparam int DRAIN_CYCLES = 12;     // settle time after the last result

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors ring state at accept time and holds the results
    // still owed by the unit, oldest first.
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        logic [7:0]          in_ring  [NT][DEPTH];
        logic [PTR_W-1:0]    in_wr_ptr [NT];
        logic [PTR_W-1:0]    in_rd_ptr [NT];
        logic [8:0]          in_fill   [NT];
        logic [8:0]          out_fill  [NT];
        logic [3:0]          cur_term;
        mtrb_pkg::out_word_t owed_q[$];
        int unsigned         mismatches;

        function new();
            for (int t = 0; t < NT; t++) begin
                in_wr_ptr[t] = '0;
                in_rd_ptr[t] = '0;
                in_fill[t]   = '0;
                out_fill[t]  = '0;
            end
            cur_term   = '0;
            mismatches = 0;
        endfunction

        // Predict the result of one accepted input word.
        function void note_input(mtrb_pkg::in_word_t w);
            mtrb_pkg::out_word_t e;
            int                  t;
            bit                  has_term;
            e               = '0;
            e.status        = mtrb_pkg::STS_OK;
            e.last_of_burst = w.burst_last;
            has_term        = 1'b1;
            t               = 0;
            if (w.opcode == mtrb_pkg::OP_KEY) begin
                // key bytes always land on the current terminal
                t = int'(cur_term);
                if (in_fill[t] >= DEPTH) begin
                    e.status = mtrb_pkg::STS_FULL;
                end else begin
                    in_ring[t][in_wr_ptr[t]] = w.data_byte;
                    in_wr_ptr[t] = (in_wr_ptr[t] == PTR_W'(DEPTH - 1)) ? '0
                                 : in_wr_ptr[t] + 1'b1;
                    in_fill[t]++;
                end
            end else if (int'(w.terminal_index) >= NT) begin
                e.status = mtrb_pkg::STS_BAD_INDEX;
                has_term = 1'b0;
            end else begin
                t = int'(w.terminal_index);
                case (w.opcode)
                    mtrb_pkg::OP_WRITE: begin
                        // output rings are never drained
                        if (out_fill[t] >= DEPTH) begin
                            e.status = mtrb_pkg::STS_FULL;
                        end else begin
                            out_fill[t]++;
                            e.echo_valid = (w.terminal_index == cur_term);
                        end
                    end
                    mtrb_pkg::OP_READ: begin
                        if (in_fill[t] == 0) begin
                            e.status = mtrb_pkg::STS_EMPTY;
                        end else begin
                            e.read_byte  = in_ring[t][in_rd_ptr[t]];
                            in_rd_ptr[t] = (in_rd_ptr[t] == PTR_W'(DEPTH - 1)) ? '0
                                         : in_rd_ptr[t] + 1'b1;
                            in_fill[t]--;
                        end
                    end
                    mtrb_pkg::OP_SWITCH: begin
                        if (w.terminal_index == cur_term) e.status = mtrb_pkg::STS_NO_CHANGE;
                        else cur_term = w.terminal_index;
                    end
                    default: ;
                endcase
            end
            if (has_term) begin
                e.input_fill  = in_fill[t];
                e.output_fill = out_fill[t];
            end
            e.current_terminal = cur_term;
            owed_q.push_back(e);
        endfunction

        function void field_check(string name, int unsigned expv, int unsigned actv);
            if (expv != actv) begin
                $error("%s: expected %0d, got %0d", name, expv, actv);
                mismatches++;
            end
        endfunction

        // Compare one accepted result word against the oldest prediction.
        function void check_result(mtrb_pkg::out_word_t got);
            mtrb_pkg::out_word_t e;
            if (owed_q.size() == 0) begin
                $error("result word with nothing owed: %h", got);
                mismatches++;
                return;
            end
            e = owed_q.pop_front();
            field_check("status",           e.status,           got.status);
            field_check("read_byte",        e.read_byte,        got.read_byte);
            field_check("echo_valid",       e.echo_valid,       got.echo_valid);
            field_check("input_fill",       e.input_fill,       got.input_fill);
            field_check("output_fill",      e.output_fill,      got.output_fill);
            field_check("current_terminal", e.current_terminal, got.current_terminal);
            field_check("last_of_burst",    e.last_of_burst,    got.last_of_burst);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mtrb_pkg::in_word_t  s_word  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mtrb_pkg::out_word_t m_word;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    multi_terminal_ring_buffers_unit #(
        .NUM_TERMINALS(NT),
        .RING_DEPTH   (DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    ring_scoreboard sb = new();

    // ------------------------------------------------------------------------
    // Watchdog: free-running cycle count, hard stop at the limit.
    // ------------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure. Every so often a new mode is picked:
    //   0 - always ready (no stalls)
    //   1 - coin flip each cycle
    //   2 - periodic, low one cycle in eight
    //   3 - long alternating holds of ready and stall cycles
    // ------------------------------------------------------------------------
    logic [1:0]  stall_mode = 2'd0;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (cycle_count[2:0] != 3'd5);
            default: begin
                if (hold_left == 0) begin
                    m_ready   <= ~m_ready;
                    hold_left <= $urandom_range(1, 24);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // Result monitor: values read here are the ones the DUT saw at this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_word);
    end

    // ------------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts valid
    // drops for a random gap. Valid is only lowered when a gap really follows,
    // so back-to-back words never see valid drop and rise in one step.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned sent_count = 0;

    function automatic mtrb_pkg::in_word_t make_word(logic [1:0] op, logic [3:0] idx,
                                                     logic [7:0] data, logic last);
        mtrb_pkg::in_word_t w;
        w.opcode         = op;
        w.terminal_index = idx;
        w.data_byte      = data;
        w.burst_last     = last;
        return w;
    endfunction

    task automatic send_word(mtrb_pkg::in_word_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        sent_count++;
    endtask

    // Terminal choice for reads and writes: mostly the current one or another
    // valid one, sometimes out of range.
    function automatic logic [3:0] pick_term();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(NT, 15));
        if ($urandom_range(0, 1) == 0) return sb.cur_term;
        return 4'($urandom_range(0, NT - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned roll;
        int unsigned run_len;
        logic [3:0]  term;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every opcode, field extremes, empty read, no-change
        // switch, bad index on write/read/switch, key ignoring its index,
        // echo on and off, and switches of the current terminal back to 0.
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd0,  8'h00, 1'b0)); // already current
        send_word(make_word(mtrb_pkg::OP_READ,   4'd0,  8'h00, 1'b0)); // empty
        send_word(make_word(mtrb_pkg::OP_KEY,    4'd0,  8'h00, 1'b0));
        send_word(make_word(mtrb_pkg::OP_KEY,    4'd15, 8'hFF, 1'b1)); // index ignored
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd0,  8'hA5, 1'b0)); // echoed
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd3,  8'h5A, 1'b1)); // not current
        send_word(make_word(mtrb_pkg::OP_READ,   4'd0,  8'h00, 1'b0));
        send_word(make_word(mtrb_pkg::OP_READ,   4'd0,  8'hFF, 1'b0));
        send_word(make_word(mtrb_pkg::OP_READ,   4'd0,  8'h00, 1'b1)); // empty again
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd15, 8'hFF, 1'b0)); // bad index
        send_word(make_word(mtrb_pkg::OP_READ,   4'd4,  8'h00, 1'b0)); // bad index
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd8,  8'h00, 1'b1)); // bad index
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd3,  8'h00, 1'b0));
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd3,  8'hFF, 1'b0)); // echoed now
        send_word(make_word(mtrb_pkg::OP_KEY,    4'd0,  8'h81, 1'b0)); // lands on 3
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd3,  8'hFF, 1'b0)); // no change
        send_word(make_word(mtrb_pkg::OP_READ,   4'd3,  8'h00, 1'b1));
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd1,  8'h00, 1'b0));
        send_word(make_word(mtrb_pkg::OP_READ,   4'd1,  8'h00, 1'b0));
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd1,  8'h00, 1'b1));
        send_word(make_word(mtrb_pkg::OP_WRITE,  4'd2,  8'h7E, 1'b0));
        send_word(make_word(mtrb_pkg::OP_SWITCH, 4'd0,  8'h00, 1'b1));

        // Random runs. About one run in five is long enough to fill a ring,
        // so full drops, long drains and pointer wraparound all get hit.
        sent_count = 0;
        while (sent_count < TARGET_ITEMS) begin
            roll    = $urandom_range(0, 9);
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(240, 280)
                                                  : $urandom_range(1, 24);
            term    = pick_term();
            if (roll <= 2) begin
                for (int i = 0; i < run_len; i++)
                    send_word(make_word(mtrb_pkg::OP_KEY, 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)), i == run_len - 1));
            end else if (roll <= 4) begin
                for (int i = 0; i < run_len; i++)
                    send_word(make_word(mtrb_pkg::OP_READ, term,
                                        8'($urandom_range(0, 255)), i == run_len - 1));
            end else if (roll <= 6) begin
                for (int i = 0; i < run_len; i++)
                    send_word(make_word(mtrb_pkg::OP_WRITE, term,
                                        8'($urandom_range(0, 255)), i == run_len - 1));
            end else if (roll == 7) begin
                term = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, NT - 1))
                                                  : 4'($urandom_range(0, 15));
                send_word(make_word(mtrb_pkg::OP_SWITCH, term, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1))));
            end else begin
                // noise: any field, any value
                run_len = $urandom_range(1, 16);
                for (int i = 0; i < run_len; i++)
                    send_word(make_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                        8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
            end
        end
        s_valid <= 1'b0;

        // Drain; the watchdog catches a unit that never delivers.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
